### design/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int CFG_W  = 4;
    localparam int BYTE_W = 22;
    localparam int STAT_W = 2;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_TOO_LARGE = 2'd1;
    localparam status_t STAT_NO_SPACE  = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic REG_TIER_COUNT      = 1'b1;

    localparam logic [CFG_W-1:0] BSL_RESET   = 4'd7;
    localparam logic [CFG_W-1:0] TIERS_RESET = 4'd11;
    localparam logic [CFG_W-1:0] BSL_MIN     = 4'd4;
    localparam logic [CFG_W-1:0] BSL_MAX     = 4'd12;

endpackage

`default_nettype wire

### design/buddy_block_allocator.sv
`default_nettype none

// Buddy allocator over a pool of 2^(tier_count-1) basic blocks, at most MAX_BLOCKS. After
// reset and after every configuration write the block runs a clearing pass over its tree
// memory and accepts no request meanwhile. An allocate request sizes the block tier by tier,
// examines tree nodes in the search for the lowest free block (up to 2*2^(tier_count-1)
// nodes), splits the found block down level by level, and hands over the result. A free
// request checks the offset, clears its allocation record and merges with free buddies level
// by level; a rejected offset goes straight to the result. The tree's node flags sit in one
// single-port read, single-port write memory; a second memory holds each allocated tier.
module buddy_block_allocator #(
    parameter int MAX_BLOCKS   = bba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [bba_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        func,
    input  wire logic [bba_pkg::BYTE_W-1:0]  request_bytes,
    input  wire logic [bba_pkg::BYTE_W-1:0]  payload_offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bba_pkg::STAT_W-1:0]       status,
    output logic [bba_pkg::BYTE_W-1:0]       granted_offset
);
    import bba_pkg::*;

    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int NW  = AW + 1;
    localparam int TLW = $clog2(AW + 2);

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_TIER  = 12'b000000000100,
        ST_SRD   = 12'b000000001000,
        ST_SCHK  = 12'b000000010000,
        ST_SPLIT = 12'b000000100000,
        ST_FREE0 = 12'b000001000000,
        ST_FRD   = 12'b000010000000,
        ST_FCHK  = 12'b000100000000,
        ST_MRD   = 12'b001000000000,
        ST_MCHK  = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  bsl_reg, bsl_next;
    logic [CFG_W-1:0]  tiers_reg, tiers_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [BYTE_W-1:0] op_reg, op_next;
    logic [BYTE_W:0]   need_reg, need_next;
    logic [TLW-1:0]    t_reg, t_next;
    logic [TLW-1:0]    s_reg, s_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     base_reg, base_next;
    logic [AW-1:0]     a_reg, a_next;
    status_t           res_stat_reg, res_stat_next;
    logic [BYTE_W-1:0] res_off_reg, res_off_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [BYTE_W-1:0] goff_reg, goff_next;

    logic              fm_mem [2*MAX_BLOCKS];
    logic              fm_rd;
    logic              fm_we;
    logic [NW-1:0]     fm_wa;
    logic              fm_wd;
    logic [NW-1:0]     fm_ra;

    logic [TLW:0]      um_mem [MAX_BLOCKS];
    logic [TLW:0]      um_rd;
    logic              um_we;
    logic [AW-1:0]     um_wa;
    logic [TLW:0]      um_wd;

    logic [TLW-1:0]    lvl_c;
    logic [CFG_W-1:0]  bs_c;
    logic [31:0]       cap_c;
    logic [NW-1:0]     j_c;
    logic [BYTE_W-1:0] rel_c;
    logic [BYTE_W-1:0] mask_c;
    logic [BYTE_W-1:0] arel_c;
    logic [TLW-1:0]    tf_c;
    logic [31:0]       gofs_c;

    always_comb
    begin
        if (tiers_reg == '0)
        begin
            lvl_c = '0;
        end
        else if ({28'd0, tiers_reg} > 32'(AW + 1))
        begin
            lvl_c = TLW'(AW);
        end
        else
        begin
            lvl_c = TLW'(tiers_reg - 4'd1);
        end
        if (bsl_reg < BSL_MIN)
        begin
            bs_c = BSL_MIN;
        end
        else if (bsl_reg > BSL_MAX)
        begin
            bs_c = BSL_MAX;
        end
        else
        begin
            bs_c = bsl_reg;
        end
    end

    assign cap_c  = 32'd1 << (6'(bs_c) + 6'(t_reg));
    assign j_c    = (n_reg - base_reg) << s_reg;
    assign rel_c  = op_reg - BYTE_W'(HEADER_BYTES);
    assign mask_c = (BYTE_W'(1) << bs_c) - BYTE_W'(1);
    assign arel_c = rel_c >> bs_c;
    assign tf_c   = (um_rd[TLW-1:0] > lvl_c) ? lvl_c : um_rd[TLW-1:0];
    assign gofs_c = (32'(a_reg) << bs_c) + 32'(HEADER_BYTES);

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_wa] <= fm_wd;
        end
        fm_rd <= fm_mem[fm_ra];
    end

    always_ff @(posedge clk)
    begin
        if (um_we)
        begin
            um_mem[um_wa] <= um_wd;
        end
        um_rd <= um_mem[a_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        bsl_next       = bsl_reg;
        tiers_next     = tiers_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        need_next      = need_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        base_next      = base_reg;
        a_next         = a_reg;
        res_stat_next  = res_stat_reg;
        res_off_next   = res_off_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        goff_next      = goff_reg;
        fm_we          = 1'b0;
        fm_wa          = n_reg;
        fm_wd          = 1'b0;
        fm_ra          = n_reg;
        um_we          = 1'b0;
        um_wa          = a_reg;
        um_wd          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                fm_we = 1'b1;
                fm_wa = cnt_reg;
                fm_wd = (cnt_reg == NW'(1));
                um_we = ~cnt_reg[NW-1];
                um_wa = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_ALLOC)
                    begin
                        need_next  = {1'b0, request_bytes} + (BYTE_W + 1)'(HEADER_BYTES);
                        t_next     = '0;
                        state_next = ST_TIER;
                    end
                    else
                    begin
                        op_next    = payload_offset;
                        state_next = ST_FREE0;
                    end
                end
            end
            ST_TIER:
            begin
                if (t_reg > lvl_c)
                begin
                    res_stat_next = STAT_TOO_LARGE;
                    res_off_next  = '0;
                    state_next    = ST_DONE;
                end
                else if (cap_c >= 32'(need_reg))
                begin
                    base_next  = NW'(1) << (lvl_c - t_reg);
                    n_next     = NW'(1) << (lvl_c - t_reg);
                    s_next     = t_reg;
                    state_next = ST_SRD;
                end
                else
                begin
                    t_next = t_reg + TLW'(1);
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (fm_rd)
                begin
                    fm_we      = 1'b1;
                    fm_wd      = 1'b0;
                    a_next     = j_c[AW-1:0];
                    state_next = ST_SPLIT;
                end
                else if (n_reg == ((base_reg << 1) - NW'(1)))
                begin
                    if (base_reg == NW'(1))
                    begin
                        res_stat_next = STAT_NO_SPACE;
                        res_off_next  = '0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        base_next  = base_reg >> 1;
                        n_next     = base_reg >> 1;
                        s_next     = s_reg + TLW'(1);
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    n_next     = n_reg + NW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_SPLIT:
            begin
                if (s_reg > t_reg)
                begin
                    fm_we  = 1'b1;
                    fm_wa  = {n_reg[NW-2:0], 1'b1};
                    fm_wd  = 1'b1;
                    n_next = {n_reg[NW-2:0], 1'b0};
                    s_next = s_reg - TLW'(1);
                end
                else
                begin
                    um_we         = 1'b1;
                    um_wd         = {1'b1, t_reg};
                    res_stat_next = STAT_OK;
                    res_off_next  = gofs_c[BYTE_W-1:0];
                    state_next    = ST_DONE;
                end
            end
            ST_FREE0:
            begin
                res_stat_next = STAT_OK;
                res_off_next  = '0;
                if ((op_reg < BYTE_W'(HEADER_BYTES)) || ((rel_c & mask_c) != '0)
                    || ((arel_c >> lvl_c) != '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    a_next     = arel_c[AW-1:0];
                    state_next = ST_FRD;
                end
            end
            ST_FRD:
            begin
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                if (!um_rd[TLW])
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    um_we  = 1'b1;
                    um_wd  = '0;
                    t_next = tf_c;
                    n_next = (NW'(1) << (lvl_c - tf_c)) + (NW'({1'b0, a_reg}) >> tf_c);
                    if (tf_c < lvl_c)
                    begin
                        state_next = ST_MRD;
                    end
                    else
                    begin
                        state_next = ST_MCHK;
                        t_next     = lvl_c;
                    end
                end
            end
            ST_MRD:
            begin
                fm_ra      = n_reg ^ NW'(1);
                state_next = ST_MCHK;
            end
            ST_MCHK:
            begin
                if ((t_reg < lvl_c) && fm_rd)
                begin
                    fm_we  = 1'b1;
                    fm_wa  = n_reg ^ NW'(1);
                    fm_wd  = 1'b0;
                    n_next = n_reg >> 1;
                    t_next = t_reg + TLW'(1);
                    if ((t_reg + TLW'(1)) < lvl_c)
                    begin
                        state_next = ST_MRD;
                    end
                    else
                    begin
                        t_next     = lvl_c;
                        state_next = ST_MCHK;
                    end
                end
                else
                begin
                    fm_we      = 1'b1;
                    fm_wa      = n_reg;
                    fm_wd      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_stat_reg;
                    goff_next      = res_off_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase

        if (cfg_valid)
        begin
            if (cfg_index == REG_BLOCK_SIZE_LOG2)
            begin
                bsl_next = cfg_data;
            end
            else
            begin
                tiers_next = cfg_data;
            end
            cnt_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            bsl_reg       <= BSL_RESET;
            tiers_reg     <= TIERS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bsl_reg       <= bsl_next;
            tiers_reg     <= tiers_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        need_reg     <= need_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        n_reg        <= n_next;
        base_reg     <= base_next;
        a_reg        <= a_next;
        res_stat_reg <= res_stat_next;
        res_off_reg  <= res_off_next;
        status_reg   <= status_next;
        goff_reg     <= goff_next;
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = goff_reg;

endmodule

`default_nettype wire

### design/bba_chk.sv
`default_nettype none

module bba_chk #(
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cfg_valid,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [bba_pkg::STAT_W-1:0]  status,
    input wire logic [bba_pkg::BYTE_W-1:0]  granted_offset
);
    import bba_pkg::*;

    localparam logic [3:0] HDR_LOW = 4'(HEADER_BYTES);

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !cfg_valid) |=> !in_ready)
        else $error("request accepted while a previous one is in progress");

    a_error_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_OK)) |-> (granted_offset == '0))
        else $error("error result carries a non-zero offset");

    a_offset_alignment: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_OK) && (granted_offset != '0))
            |-> (granted_offset[3:0] == HDR_LOW))
        else $error("granted offset is not header-aligned");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(granted_offset)))
        else $error("result changed before it was taken");

endmodule

bind buddy_block_allocator bba_chk #(.HEADER_BYTES(HEADER_BYTES)) u_bba_chk (.*);

`default_nettype wire
